/* hdl/wfg_pkg.sv */
// Shared types and constants of the wait-for graph cycle detector.
`default_nettype none
package wfg_pkg;

   localparam int TASK_W = 3;
   localparam int RES_W = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic             valid;
      logic [RES_W-1:0] res;
   } rec_type;

   typedef struct packed {
      logic              task_ok;
      logic [TASK_W-1:0] task_idx;
      rec_type           wait_rec;
      rec_type           hold_rec;
   } upd_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ROOT = 4'b0010,
      ST_WALK = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

endpackage
`default_nettype wire

/* hdl/wfg_front.sv */
// Front end: accepts update items, classifies them into records and queues them.
`default_nettype none
module wfg_front
   import wfg_pkg::*;
#(
   parameter int NUM_TASKS = 8,
   parameter int NUM_RESOURCES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [TASK_W-1:0] req_task_req,
   input  wire logic              req_wait_valid,
   input  wire logic [RES_W-1:0]  req_wait_resource,
   input  wire logic              req_hold_valid,
   input  wire logic [RES_W-1:0]  req_hold_resource,
   output logic                   q_valid,
   input  wire logic              q_take,
   output upd_type                q_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   upd_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   upd_type              upd;
   logic                 push;
   logic                 pop;

   always_comb begin
      upd.task_ok = int'(req_task_req) < NUM_TASKS;
      upd.task_idx = req_task_req;
      upd.wait_rec.valid = req_wait_valid && (int'(req_wait_resource) < NUM_RESOURCES);
      upd.wait_rec.res = upd.wait_rec.valid ? req_wait_resource : '0;
      upd.hold_rec.valid = req_hold_valid && (int'(req_hold_resource) < NUM_RESOURCES);
      upd.hold_rec.res = upd.hold_rec.valid ? req_hold_resource : '0;
   end

   assign req_stall = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_take;
   assign q_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= upd;
      end
   end

endmodule
`default_nettype wire

/* hdl/wfg_walker.sv */
// Back end: record tables and the depth-first walk that searches for a cycle.
`default_nettype none
module wfg_walker
   import wfg_pkg::*;
#(
   parameter int NUM_TASKS = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   output logic         q_take,
   input  wire upd_type q_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic         rsp_deadlock_found
);

   localparam int TW = $clog2(NUM_TASKS);
   localparam int CW = $clog2(NUM_TASKS + 1);

   state_type              state_ff, state_in;
   rec_type                wait_ff [NUM_TASKS];
   rec_type                wait_in [NUM_TASKS];
   rec_type                hold_ff [NUM_TASKS];
   rec_type                hold_in [NUM_TASKS];
   logic [TW-1:0]          stk_ff [NUM_TASKS];
   logic [TW-1:0]          stk_in [NUM_TASKS];
   logic [CW-1:0]          cur_ff [NUM_TASKS];
   logic [CW-1:0]          cur_in [NUM_TASKS];
   logic [NUM_TASKS-1:0]   visited_ff, visited_in;
   logic [NUM_TASKS-1:0]   onpath_ff, onpath_in;
   logic [CW-1:0]          sp_ff, sp_in;
   logic [CW-1:0]          root_ff, root_in;
   logic                   found_ff, found_in;
   logic [CW-1:0]          sp_m1;
   logic [TW-1:0]          top_idx;
   logic [TW-1:0]          sp_idx;
   logic [TW-1:0]          root_idx;
   logic [TW-1:0]          node;
   logic [CW-1:0]          cur_top;
   logic [TW-1:0]          v_idx;
   logic                   edge_hit;

   assign sp_m1 = sp_ff - CW'(1);
   assign top_idx = sp_m1[TW-1:0];
   assign sp_idx = sp_ff[TW-1:0];
   assign root_idx = root_ff[TW-1:0];
   assign node = stk_ff[top_idx];
   assign cur_top = cur_ff[top_idx];
   assign v_idx = cur_top[TW-1:0];
   assign edge_hit = wait_ff[node].valid && hold_ff[v_idx].valid
                     && (wait_ff[node].res == hold_ff[v_idx].res);

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_deadlock_found = found_ff;

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      hold_in = hold_ff;
      stk_in = stk_ff;
      cur_in = cur_ff;
      visited_in = visited_ff;
      onpath_in = onpath_ff;
      sp_in = sp_ff;
      root_in = root_ff;
      found_in = found_ff;
      q_take = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               for (int i = 0; i < NUM_TASKS; i++) begin
                  if (q_data.task_ok && (int'(q_data.task_idx) == i)) begin
                     wait_in[i] = q_data.wait_rec;
                     hold_in[i] = q_data.hold_rec;
                  end
               end
               visited_in = '0;
               onpath_in = '0;
               root_in = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_ff == CW'(NUM_TASKS)) begin
               found_in = 1'b0;
               state_in = ST_OUT;
            end else if (visited_ff[root_idx]) begin
               root_in = root_ff + CW'(1);
            end else begin
               stk_in[0] = root_idx;
               cur_in[0] = '0;
               visited_in[root_idx] = 1'b1;
               onpath_in[root_idx] = 1'b1;
               sp_in = CW'(1);
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (cur_top == CW'(NUM_TASKS)) begin
               onpath_in[node] = 1'b0;
               sp_in = sp_m1;
               if (sp_ff == CW'(1)) begin
                  root_in = root_ff + CW'(1);
                  state_in = ST_ROOT;
               end
            end else begin
               cur_in[top_idx] = cur_top + CW'(1);
               if (edge_hit) begin
                  if (!visited_ff[v_idx]) begin
                     if (sp_ff < CW'(NUM_TASKS)) begin
                        stk_in[sp_idx] = v_idx;
                        cur_in[sp_idx] = '0;
                        sp_in = sp_ff + CW'(1);
                        visited_in[v_idx] = 1'b1;
                        onpath_in[v_idx] = 1'b1;
                     end
                  end else if (onpath_ff[v_idx]) begin
                     found_in = 1'b1;
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < NUM_TASKS; i++) begin
            wait_ff[i] <= '0;
            hold_ff[i] <= '0;
         end
         visited_ff <= '0;
         onpath_ff <= '0;
         sp_ff <= '0;
         root_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         hold_ff <= hold_in;
         visited_ff <= visited_in;
         onpath_ff <= onpath_in;
         sp_ff <= sp_in;
         root_ff <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      stk_ff <= stk_in;
      cur_ff <= cur_in;
      found_ff <= found_in;
   end

endmodule
`default_nettype wire

/* hdl/wait_for_graph_cycle_detector.sv */
// Top level of the wait-for graph cycle detector.
// Each item replaces one task's wait and hold record and returns one flag that tells
// whether the updated wait-for graph holds a directed cycle, a self-loop included.
// A two-entry queue takes items while the walker is busy or while a result waits.
// The walker checks one candidate edge per cycle in a depth-first search. The search
// stops at the first cycle that it finds, as when task 0 waits on a resource it holds itself,
// and runs over every root whenever the graph has no cycle; a stalled result holds the
// walker until it is taken.
`default_nettype none
module wait_for_graph_cycle_detector
   import wfg_pkg::*;
#(
   parameter int NUM_TASKS = 8,
   parameter int NUM_RESOURCES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [TASK_W-1:0] req_task_req,
   input  wire logic              req_wait_valid,
   input  wire logic [RES_W-1:0]  req_wait_resource,
   input  wire logic              req_hold_valid,
   input  wire logic [RES_W-1:0]  req_hold_resource,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_deadlock_found
);

   logic    q_valid;
   logic    q_take;
   upd_type q_data;

   wfg_front #(
      .NUM_TASKS(NUM_TASKS),
      .NUM_RESOURCES(NUM_RESOURCES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_task_req(req_task_req),
      .req_wait_valid(req_wait_valid),
      .req_wait_resource(req_wait_resource),
      .req_hold_valid(req_hold_valid),
      .req_hold_resource(req_hold_resource),
      .q_valid(q_valid),
      .q_take(q_take),
      .q_data(q_data)
   );

   wfg_walker #(
      .NUM_TASKS(NUM_TASKS)
   ) u_walker (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_take(q_take),
      .q_data(q_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_deadlock_found(rsp_deadlock_found)
   );

`ifndef SYNTHESIS
   a_take_not_while_result: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && q_take))
      else $error("walker took a queued item while a result was pending");

   a_take_then_walk: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_take) |=> !rsp_valid)
      else $error("result appeared in the cycle after an item was taken");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("a second result followed an accepted result at once");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Testbench for the wait-for graph cycle detector with a predictor.
`timescale 1ns / 100ps
module tb_top;
   import wfg_pkg::*;

   localparam int NTASK = 8;
   localparam int NRES = 8;
   localparam int IDLE_PCT = 32;
   localparam int RANDOM_ITEMS = 1530;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int HOLDOFF_AT = 400;
   localparam int QUIET_LO = 700;
   localparam int QUIET_HI = 900;
   localparam int DRAIN_EVERY = 300;
   localparam int TAIL_CYCLES = 200;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic [TASK_W-1:0] task_idx;
      logic              wv;
      logic [RES_W-1:0]  wr;
      logic              hv;
      logic [RES_W-1:0]  hr;
      bit                drain;
   } lock_upd_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [TASK_W-1:0] req_task_req = '0;
   logic              req_wait_valid = 1'b0;
   logic [RES_W-1:0]  req_wait_resource = '0;
   logic              req_hold_valid = 1'b0;
   logic [RES_W-1:0]  req_hold_resource = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_deadlock_found;

   lock_upd_type pending_upd[$];
   logic         deadlock_expect[$];
   lock_upd_type offered_upd;
   rec_type      wait_rec_q [NTASK];
   rec_type      hold_rec_q [NTASK];
   int           sent_count = 0;
   int           recv_count = 0;
   int           error_count = 0;
   int           holdoff_left = 0;
   bit           holdoff_done = 1'b0;
   int           stuck_cycles = 0;

   wait_for_graph_cycle_detector dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_task_req       (req_task_req),
      .req_wait_valid     (req_wait_valid),
      .req_wait_resource  (req_wait_resource),
      .req_hold_valid     (req_hold_valid),
      .req_hold_resource  (req_hold_resource),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_deadlock_found (rsp_deadlock_found)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < NTASK; i++) begin
         wait_rec_q[i] = '0;
         hold_rec_q[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic rec_type make_rec(logic v, logic [RES_W-1:0] r);
      rec_type rec;
      rec = '0;
      if (v && (int'(r) < NRES)) begin
         rec.valid = 1'b1;
         rec.res = r;
      end
      return rec;
   endfunction

   // Transitive closure of the wait-for graph; a cycle shows up as a task reaching itself.
   function automatic logic graph_has_cycle();
      logic [NTASK-1:0] reach [NTASK];
      logic             found;
      found = 1'b0;
      for (int i = 0; i < NTASK; i++) begin
         for (int j = 0; j < NTASK; j++) begin
            reach[i][j] = wait_rec_q[i].valid && hold_rec_q[j].valid &&
                          (wait_rec_q[i].res == hold_rec_q[j].res);
         end
      end
      for (int k = 0; k < NTASK; k++) begin
         for (int i = 0; i < NTASK; i++) begin
            if (reach[i][k]) begin
               reach[i] = reach[i] | reach[k];
            end
         end
      end
      for (int i = 0; i < NTASK; i++) begin
         if (reach[i][i]) begin
            found = 1'b1;
         end
      end
      return found;
   endfunction

   task automatic add_upd(int t, bit wv, int wr, bit hv, int hr, bit drain);
      lock_upd_type u;
      u.task_idx = t[TASK_W-1:0];
      u.wv = wv;
      u.wr = wr[RES_W-1:0];
      u.hv = hv;
      u.hr = hr[RES_W-1:0];
      u.drain = drain;
      pending_upd.push_back(u);
   endtask

   // Driver.
   always @(posedge clock) begin : drive_p
      bit fired;
      bit launch;
      bit quiet;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fired = req_valid && !req_stall;
         quiet = (sent_count >= QUIET_LO) && (sent_count < QUIET_HI);
         if (fired) begin
            if (int'(offered_upd.task_idx) < NTASK) begin
               wait_rec_q[offered_upd.task_idx] = make_rec(offered_upd.wv, offered_upd.wr);
               hold_rec_q[offered_upd.task_idx] = make_rec(offered_upd.hv, offered_upd.hr);
            end
            deadlock_expect.push_back(graph_has_cycle());
            sent_count <= sent_count + 1;
         end
         if (!req_valid || fired) begin
            launch = pending_upd.size() != 0;
            if (launch && pending_upd[0].drain) begin
               launch = !fired && (sent_count == recv_count);
            end
            if (launch && !quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
               launch = 1'b0;
            end
            if (launch) begin
               offered_upd = pending_upd.pop_front();
               req_task_req <= offered_upd.task_idx;
               req_wait_valid <= offered_upd.wv;
               req_wait_resource <= offered_upd.wr;
               req_hold_valid <= offered_upd.hv;
               req_hold_resource <= offered_upd.hr;
            end
            req_valid <= launch;
         end
      end
   end

   // Monitor and result-side stall.
   always @(posedge clock) begin : monitor_p
      logic want;
      bit   quiet;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         quiet = (recv_count >= QUIET_LO) && (recv_count < QUIET_HI);
         if (rsp_valid && !rsp_stall) begin
            if (deadlock_expect.size() == 0) begin
               $display("%0t ERROR unexpected result: expected none, actual deadlock_found=%0b",
                        $time, rsp_deadlock_found);
               error_count++;
            end else begin
               want = deadlock_expect.pop_front();
               if (rsp_deadlock_found !== want) begin
                  $display("%0t ERROR deadlock_found: expected %0b, actual %0b",
                           $time, want, rsp_deadlock_found);
                  error_count++;
               end
            end
            recv_count <= recv_count + 1;
         end
         if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            rsp_stall <= 1'b1;
         end else if (!holdoff_done && (recv_count >= HOLDOFF_AT)) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : watchdog_p
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ERROR no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus_p
      int perm [NTASK];
      int rperm [NRES];
      int tmp;
      int pick;
      int k;
      int mode;
      int wden;
      int hden;
      bit drain;

      // Self-loops at both ends of the ranges and flags off with stray resource bits.
      add_upd(0, 1, 0, 1, 0, 0);
      add_upd(0, 0, 7, 0, 7, 0);
      add_upd(7, 1, 7, 1, 7, 0);
      add_upd(7, 0, 5, 1, 7, 0);
      add_upd(6, 1, 7, 1, 6, 0);
      add_upd(7, 1, 6, 1, 7, 0);
      add_upd(7, 1, 6, 0, 3, 0);
      // A chain over all tasks that closes into one long cycle on the last item.
      for (int i = 0; i < NTASK; i++) begin
         add_upd(i, 1, (i + 1) % NTASK, 1, i, 0);
      end
      // Several tasks hold the same resource.
      add_upd(7, 0, 0, 0, 0, 0);
      add_upd(4, 1, 5, 1, 0, 0);
      add_upd(7, 1, 0, 1, 7, 0);
      for (int i = 0; i < NTASK; i++) begin
         add_upd(i, 0, 0, 0, 0, i == 0);
      end

      wden = 50;
      hden = 70;
      while (pending_upd.size() < RANDOM_ITEMS + 25) begin
         drain = (pending_upd.size() % DRAIN_EVERY) == 0;
         if ((pending_upd.size() % 32) == 0) begin
            wden = $urandom_range(10, 90);
            hden = $urandom_range(20, 95);
         end
         mode = $urandom_range(0, 99);
         if (mode < 60) begin
            add_upd($urandom_range(0, NTASK - 1), $urandom_range(0, 99) < wden,
                    $urandom_range(0, NRES - 1), $urandom_range(0, 99) < hden,
                    $urandom_range(0, NRES - 1), drain);
         end else if (mode < 85) begin
            for (int i = 0; i < NTASK; i++) begin
               perm[i] = i;
            end
            for (int i = 0; i < NRES; i++) begin
               rperm[i] = i;
            end
            for (int i = NTASK - 1; i > 0; i--) begin
               pick = $urandom_range(0, i);
               tmp = perm[i];
               perm[i] = perm[pick];
               perm[pick] = tmp;
               pick = $urandom_range(0, i);
               tmp = rperm[i];
               rperm[i] = rperm[pick];
               rperm[pick] = tmp;
            end
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) begin
               add_upd(perm[i], 1, rperm[(i + 1) % k], 1, rperm[i], drain && (i == 0));
            end
         end else if (mode < 93) begin
            add_upd($urandom, 1'($urandom), $urandom, 1'($urandom), $urandom, drain);
         end else begin
            add_upd($urandom_range(0, NTASK - 1), 0, $urandom, 0, $urandom, drain);
         end
      end

      @(posedge clock);
      while (reset || (pending_upd.size() != 0) || req_valid) begin
         @(posedge clock);
      end
      while (recv_count < sent_count) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      while (deadlock_expect.size() != 0) begin
         $display("%0t ERROR missing result: expected deadlock_found=%0b, actual none",
                  $time, deadlock_expect.pop_front());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
